/* sv/cbcr_pkg.sv */
// Shared types and constants for the circle versus box collision resolver.
package cbcr_pkg;

  // Reset value of the contact tolerance register
  localparam logic [15:0] TOL_RESET = 16'd1;

  // Clock edges from request acceptance to the result strobe
  localparam int PIPE_LAT = 76;

  // Sideband carried alongside the square root pipeline
  typedef struct packed {
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic [31:0]        cx;
    logic [31:0]        cy;
    logic [30:0]        radius;
    logic               trig;
    logic               far;
  } sq_sb_t;

  // Sideband carried alongside the divider pipeline
  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic        hit;
    logic        moved;
    logic        degen;
    logic        neg_x;
    logic        neg_y;
  } dv_sb_t;

  localparam int SQ_SB_W = $bits(sq_sb_t);
  localparam int DV_SB_W = $bits(dv_sb_t);

endpackage

/* sv/cbcr_sqrt.sv */
// Pipelined integer square root, one root bit per stage, with sideband.
module cbcr_sqrt #(
  parameter int SB_W = cbcr_pkg::SQ_SB_W
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [63:0]     in_rad,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_valid,
  output logic [31:0]     out_root,
  output logic [SB_W-1:0] out_sb
);

  logic [32:0]     vld_r;
  logic [63:0]     val_r  [33];
  logic [33:0]     rem_r  [33];
  logic [31:0]     root_r [33];
  logic [SB_W-1:0] sb_r   [33];

  // Capture the radicand
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
    val_r[0]  <= in_rad;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
    sb_r[0]   <= in_sb;
  end

  // One restoring step per stage: bring in two radicand bits, try root*4+1
  for (genvar i = 0; i < 32; i++) begin : g_step
    logic [35:0] trial;
    logic [35:0] diff;
    assign trial = {rem_r[i], val_r[i][63:62]};
    assign diff  = trial - {2'b00, root_r[i], 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      val_r[i+1] <= {val_r[i][61:0], 2'b00};
      sb_r[i+1]  <= sb_r[i];
      if (!diff[35]) begin
        rem_r[i+1]  <= diff[33:0];
        root_r[i+1] <= {root_r[i][30:0], 1'b1};
      end else begin
        rem_r[i+1]  <= trial[33:0];
        root_r[i+1] <= {root_r[i][30:0], 1'b0};
      end
    end
  end

  assign out_valid = vld_r[32];
  assign out_root  = root_r[32];
  assign out_sb    = sb_r[32];

endmodule

/* sv/cbcr_div.sv */
// Pipelined two-lane restoring divider, one quotient bit per stage, with sideband.
module cbcr_div #(
  parameter int SB_W = cbcr_pkg::DV_SB_W
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [64:0]     in_num_x,
  input  logic [64:0]     in_num_y,
  input  logic [31:0]     in_den,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_valid,
  output logic [32:0]     out_quo_x,
  output logic [32:0]     out_quo_y,
  output logic [SB_W-1:0] out_sb
);

  logic [33:0]     vld_r;
  logic [31:0]     den_r  [34];
  logic [31:0]     remx_r [34];
  logic [31:0]     remy_r [34];
  logic [32:0]     lowx_r [34];
  logic [32:0]     lowy_r [34];
  logic [32:0]     qx_r   [34];
  logic [32:0]     qy_r   [34];
  logic [SB_W-1:0] sb_r   [34];

  // Load the upper numerator bits as the starting remainder (quotient fits 33 bits)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
    den_r[0]  <= in_den;
    remx_r[0] <= in_num_x[64:33];
    remy_r[0] <= in_num_y[64:33];
    lowx_r[0] <= in_num_x[32:0];
    lowy_r[0] <= in_num_y[32:0];
    qx_r[0]   <= '0;
    qy_r[0]   <= '0;
    sb_r[0]   <= in_sb;
  end

  // Shift in one numerator bit per lane and subtract the divisor when it fits
  for (genvar i = 0; i < 33; i++) begin : g_step
    logic [32:0] tx;
    logic [32:0] ty;
    logic [33:0] dfx;
    logic [33:0] dfy;
    assign tx  = {remx_r[i], lowx_r[i][32]};
    assign ty  = {remy_r[i], lowy_r[i][32]};
    assign dfx = {1'b0, tx} - {2'b00, den_r[i]};
    assign dfy = {1'b0, ty} - {2'b00, den_r[i]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      den_r[i+1]  <= den_r[i];
      sb_r[i+1]   <= sb_r[i];
      lowx_r[i+1] <= {lowx_r[i][31:0], 1'b0};
      lowy_r[i+1] <= {lowy_r[i][31:0], 1'b0};
      qx_r[i+1]   <= {qx_r[i][31:0], ~dfx[33]};
      qy_r[i+1]   <= {qy_r[i][31:0], ~dfy[33]};
      remx_r[i+1] <= dfx[33] ? tx[31:0] : dfx[31:0];
      remy_r[i+1] <= dfy[33] ? ty[31:0] : dfy[31:0];
    end
  end

  assign out_valid = vld_r[33];
  assign out_quo_x = qx_r[33];
  assign out_quo_y = qy_r[33];
  assign out_sb    = sb_r[33];

endmodule

/* sv/circle_box_collision_resolve.sv */
// Top level of the circle versus axis-aligned box collision resolver.
// A request is taken in every clock cycle (busy stays low) and its result shows on the
// out_ ports for one cycle with out_valid; results leave in request order and the receiver
// cannot stall them. Each request passes through the 33 register stages of the square root,
// the 34 of the divider that forms the push, and nine stages for capture, clamp, magnitude,
// square, sum, decide, scale, sign split and output.
// contact_tolerance is written through cfg_data and should change only while no request
// is in flight.
module circle_box_collision_resolve (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_circle_x,
  input  logic signed [31:0] in_circle_y,
  input  logic [30:0]        in_circle_radius,
  input  logic signed [31:0] in_box_x,
  input  logic signed [31:0] in_box_y,
  input  logic [30:0]        in_box_width,
  input  logic [30:0]        in_box_height,
  input  logic               in_trigger,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  output logic               out_hit,
  output logic               out_moved,
  output logic               out_degenerate,
  output logic signed [31:0] out_new_x,
  output logic signed [31:0] out_new_y
);

  logic [15:0] tol_r;

  // Request capture stage
  logic               v1_r;
  logic signed [31:0] cx1_r, cy1_r, bx1_r, by1_r;
  logic [30:0]        rad1_r;
  logic [29:0]        hw1_r, hh1_r;
  logic               trig1_r;

  // Ray stage
  logic               v2_r;
  logic signed [33:0] dx2_r, dy2_r;
  logic [31:0]        cx2_r, cy2_r;
  logic [30:0]        rad2_r;
  logic               trig2_r;

  // Magnitude stage
  logic               v3_r;
  logic signed [33:0] dx3_r, dy3_r;
  logic [31:0]        ax3_r, ay3_r, cx3_r, cy3_r;
  logic [30:0]        rad3_r;
  logic               trig3_r, far3_r;

  // Square stage
  logic               v4_r;
  logic [63:0]        sxx4_r, syy4_r;
  cbcr_pkg::sq_sb_t   sb4_r;

  // Sum stage
  logic               v5_r;
  logic [63:0]        sum5_r;
  cbcr_pkg::sq_sb_t   sb5_r;
  cbcr_pkg::sq_sb_t   sb5_nxt;

  logic               sq_valid;
  logic [31:0]        sq_root;
  logic [cbcr_pkg::SQ_SB_W-1:0] sq_sb_raw;
  cbcr_pkg::sq_sb_t   sq_sb;

  // Decision stage
  logic               v6_r;
  logic signed [32:0] dx6_r, dy6_r, ov6_r;
  logic [31:0]        mag6_r;
  cbcr_pkg::dv_sb_t   sb6_r;

  // Product stage
  logic               v7_r;
  logic signed [65:0] px7_r, py7_r;
  logic [31:0]        mag7_r;
  cbcr_pkg::dv_sb_t   sb7_r;

  // Magnitude of product stage
  logic               v8_r;
  logic [64:0]        nx8_r, ny8_r;
  logic [31:0]        mag8_r;
  cbcr_pkg::dv_sb_t   sb8_r;
  cbcr_pkg::dv_sb_t   sb8_nxt;

  logic               dv_valid;
  logic [32:0]        dv_qx, dv_qy;
  logic [cbcr_pkg::DV_SB_W-1:0] dv_sb_raw;
  cbcr_pkg::dv_sb_t   dv_sb;

  logic               start_ok;
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign start_ok  = start & ~busy;

  // Hold the contact tolerance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= cbcr_pkg::TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tol_r <= cfg_data;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start_ok;
    end
    cx1_r   <= in_circle_x;
    cy1_r   <= in_circle_y;
    bx1_r   <= in_box_x;
    by1_r   <= in_box_y;
    rad1_r  <= in_circle_radius;
    hw1_r   <= in_box_width[30:1];
    hh1_r   <= in_box_height[30:1];
    trig1_r <= in_trigger;
  end

  // Clamp the center into the box and form the ray to the nearest point
  logic signed [33:0] cxe, cye, lox, hix, loy, hiy, nx, ny;
  always_comb begin
    cxe = {{2{cx1_r[31]}}, cx1_r};
    cye = {{2{cy1_r[31]}}, cy1_r};
    lox = {{2{bx1_r[31]}}, bx1_r} - $signed({4'b0000, hw1_r});
    hix = {{2{bx1_r[31]}}, bx1_r} + $signed({4'b0000, hw1_r});
    loy = {{2{by1_r[31]}}, by1_r} - $signed({4'b0000, hh1_r});
    hiy = {{2{by1_r[31]}}, by1_r} + $signed({4'b0000, hh1_r});
    nx  = (cxe < lox) ? lox : ((cxe > hix) ? hix : cxe);
    ny  = (cye < loy) ? loy : ((cye > hiy) ? hiy : cye);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    dx2_r   <= nx - cxe;
    dy2_r   <= ny - cye;
    cx2_r   <= cx1_r;
    cy2_r   <= cy1_r;
    rad2_r  <= rad1_r;
    trig2_r <= trig1_r;
  end

  // Take ray magnitudes per axis and flag pairs too far apart
  logic [33:0] abx, aby;
  assign abx = dx2_r[33] ? 34'(-dx2_r) : dx2_r;
  assign aby = dy2_r[33] ? 34'(-dy2_r) : dy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    dx3_r   <= dx2_r;
    dy3_r   <= dy2_r;
    ax3_r   <= abx[31:0];
    ay3_r   <= aby[31:0];
    far3_r  <= (|abx[33:32]) | (|aby[33:32]);
    cx3_r   <= cx2_r;
    cy3_r   <= cy2_r;
    rad3_r  <= rad2_r;
    trig3_r <= trig2_r;
  end

  // Square each axis
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    sxx4_r       <= ax3_r * ax3_r;
    syy4_r       <= ay3_r * ay3_r;
    sb4_r.dx     <= dx3_r;
    sb4_r.dy     <= dy3_r;
    sb4_r.cx     <= cx3_r;
    sb4_r.cy     <= cy3_r;
    sb4_r.radius <= rad3_r;
    sb4_r.trig   <= trig3_r;
    sb4_r.far    <= far3_r;
  end

  // Sum the squares; a carry out means too far apart
  logic [64:0] sum_w;
  assign sum_w = {1'b0, sxx4_r} + {1'b0, syy4_r};

  always_comb begin
    sb5_nxt     = sb4_r;
    sb5_nxt.far = sb4_r.far | sum_w[64];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    sum5_r <= sum_w[63:0];
    sb5_r  <= sb5_nxt;
  end

  cbcr_sqrt #(
    .SB_W (cbcr_pkg::SQ_SB_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v5_r),
    .in_rad    (sum5_r),
    .in_sb     (sb5_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_sb    (sq_sb_raw)
  );
  assign sq_sb = cbcr_pkg::sq_sb_t'(sq_sb_raw);

  // Decide hit, trigger and zero distance; form the overlap
  logic [32:0] reach;
  logic        hit_w, act_w, zero_w;
  assign reach  = {2'b00, sq_sb.radius} + {17'd0, tol_r};
  assign hit_w  = ~sq_sb.far & ({1'b0, sq_root} <= reach);
  assign act_w  = hit_w & ~sq_sb.trig;
  assign zero_w = (sq_root == 32'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= sq_valid;
    end
    dx6_r       <= sq_sb.dx[32:0];
    dy6_r       <= sq_sb.dy[32:0];
    ov6_r       <= $signed({2'b00, sq_sb.radius}) - $signed({1'b0, sq_root});
    mag6_r      <= sq_root;
    sb6_r.cx    <= sq_sb.cx;
    sb6_r.cy    <= sq_sb.cy;
    sb6_r.hit   <= hit_w;
    sb6_r.moved <= act_w & ~zero_w;
    sb6_r.degen <= act_w & zero_w;
    sb6_r.neg_x <= 1'b0;
    sb6_r.neg_y <= 1'b0;
  end

  // Scale the ray by the overlap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
    px7_r  <= dx6_r * ov6_r;
    py7_r  <= dy6_r * ov6_r;
    mag7_r <= mag6_r;
    sb7_r  <= sb6_r;
  end

  // Split products into magnitude and sign for the divider
  logic [65:0] apx, apy;
  assign apx = px7_r[65] ? 66'(-px7_r) : px7_r;
  assign apy = py7_r[65] ? 66'(-py7_r) : py7_r;

  always_comb begin
    sb8_nxt       = sb7_r;
    sb8_nxt.neg_x = px7_r[65];
    sb8_nxt.neg_y = py7_r[65];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= v7_r;
    end
    nx8_r  <= apx[64:0];
    ny8_r  <= apy[64:0];
    mag8_r <= mag7_r;
    sb8_r  <= sb8_nxt;
  end

  cbcr_div #(
    .SB_W (cbcr_pkg::DV_SB_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v8_r),
    .in_num_x  (nx8_r),
    .in_num_y  (ny8_r),
    .in_den    (mag8_r),
    .in_sb     (sb8_r),
    .out_valid (dv_valid),
    .out_quo_x (dv_qx),
    .out_quo_y (dv_qy),
    .out_sb    (dv_sb_raw)
  );
  assign dv_sb = cbcr_pkg::dv_sb_t'(dv_sb_raw);

  // Apply the push with truncation toward zero and saturate
  logic signed [33:0] pushx, pushy;
  logic signed [34:0] newx, newy;
  logic [31:0]        satx, saty;
  always_comb begin
    pushx = dv_sb.neg_x ? 34'(-$signed({1'b0, dv_qx})) : $signed({1'b0, dv_qx});
    pushy = dv_sb.neg_y ? 34'(-$signed({1'b0, dv_qy})) : $signed({1'b0, dv_qy});
    newx  = $signed({{3{dv_sb.cx[31]}}, dv_sb.cx}) - $signed({pushx[33], pushx});
    newy  = $signed({{3{dv_sb.cy[31]}}, dv_sb.cy}) - $signed({pushy[33], pushy});
    if ((newx[34:31] == 4'b0000) || (newx[34:31] == 4'b1111)) begin
      satx = newx[31:0];
    end else begin
      satx = newx[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    if ((newy[34:31] == 4'b0000) || (newy[34:31] == 4'b1111)) begin
      saty = newy[31:0];
    end else begin
      saty = newy[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  end

  // Register the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_valid;
    end
    out_hit        <= dv_sb.hit;
    out_moved      <= dv_sb.moved;
    out_degenerate <= dv_sb.degen;
    out_new_x      <= dv_sb.moved ? satx : dv_sb.cx;
    out_new_y      <= dv_sb.moved ? saty : dv_sb.cy;
  end

endmodule

/* sv/cbcr_checker.sv */
// Port-level checker for the collision resolver, bound to the top level.
module cbcr_port_props (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [31:0] in_circle_x,
  input logic [31:0] in_circle_y,
  input logic        out_valid,
  input logic        out_hit,
  input logic        out_moved,
  input logic        out_degenerate,
  input logic [31:0] out_new_x,
  input logic [31:0] out_new_y
);

  localparam int LAT = cbcr_pkg::PIPE_LAT;

  // A result only follows an accepted request at the fixed latency
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, LAT))
    else $error("result without matching request");

  // A move needs a hit and a push direction
  a_move: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_moved |-> out_hit && !out_degenerate)
    else $error("move without hit or with zero distance");

  // A miss reports nothing else
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> !out_moved && !out_degenerate)
    else $error("flags set on a miss");

  // An unmoved result returns the requested center
  a_keep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_moved |->
      out_new_x == $past(in_circle_x, LAT) && out_new_y == $past(in_circle_y, LAT))
    else $error("center changed without a move");

endmodule

bind circle_box_collision_resolve cbcr_port_props u_cbcr_port_props (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_circle_x    (in_circle_x),
  .in_circle_y    (in_circle_y),
  .out_valid      (out_valid),
  .out_hit        (out_hit),
  .out_moved      (out_moved),
  .out_degenerate (out_degenerate),
  .out_new_x      (out_new_x),
  .out_new_y      (out_new_y)
);

/* sim/cbcr_checker.sv */
// Checker for the collision resolver: predicts each result and compares it with the block.
module cbcr_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] in_circle_x,
  input  logic signed [31:0] in_circle_y,
  input  logic [30:0]        in_circle_radius,
  input  logic signed [31:0] in_box_x,
  input  logic signed [31:0] in_box_y,
  input  logic [30:0]        in_box_width,
  input  logic [30:0]        in_box_height,
  input  logic               in_trigger,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  input  logic               out_valid,
  input  logic               out_hit,
  input  logic               out_moved,
  input  logic               out_degenerate,
  input  logic signed [31:0] out_new_x,
  input  logic signed [31:0] out_new_y,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        hit;
    logic        moved;
    logic        degen;
    logic [31:0] nx;
    logic [31:0] ny;
  } resolve_t;

  resolve_t          resolve_q[$];
  logic [15:0]       tolerance;

  // Floor square root of a 64-bit value, bit by bit
  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
    if (v < -64'sh80000000) v = -64'sh80000000;
    return v[31:0];
  endfunction

  // Clamp the center into the box, measure, and push out along the ray
  function automatic resolve_t resolve(longint cx, longint cy, longint rad, longint bx,
                                       longint by, longint hw, longint hh, logic trig);
    resolve_t    r;
    longint      px, py, dx, dy, mag, ovl;
    logic [63:0] ax, ay, sxx, syy, sum;
    px = (cx < bx - hw) ? bx - hw : ((cx > bx + hw) ? bx + hw : cx);
    py = (cy < by - hh) ? by - hh : ((cy > by + hh) ? by + hh : cy);
    dx = px - cx;
    dy = py - cy;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    r = '{hit: 1'b0, moved: 1'b0, degen: 1'b0, nx: cx[31:0], ny: cy[31:0]};
    if (ax < 64'h1_0000_0000 && ay < 64'h1_0000_0000) begin
      sxx = ax * ax;
      syy = ay * ay;
      sum = sxx + syy;
      if (sum >= sxx) begin
        mag = longint'(floor_root(sum));
        if (mag <= rad + longint'(tolerance)) begin
          r.hit = 1'b1;
          if (!trig) begin
            if (mag == 0) begin
              r.degen = 1'b1;
            end else begin
              ovl = rad - mag;
              r.nx = clip32(cx - (dx * ovl) / mag);
              r.ny = clip32(cy - (dy * ovl) / mag);
              r.moved = 1'b1;
            end
          end
        end
      end
    end
    return r;
  endfunction

  assign pending = resolve_q.size();

  // Predict on each accepted request, compare each strobed result
  always @(posedge clk) begin
    resolve_t e;
    resolve_t got;
    if (!rst_n) begin
      tolerance <= cbcr_pkg::TOL_RESET;
      resolve_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) tolerance <= cfg_data;
      if (start && !busy) begin
        resolve_q.push_back(resolve(longint'(in_circle_x), longint'(in_circle_y),
          longint'(in_circle_radius), longint'(in_box_x), longint'(in_box_y),
          longint'(in_box_width >> 1), longint'(in_box_height >> 1), in_trigger));
      end
      if (out_valid) begin
        got = '{hit: out_hit, moved: out_moved, degen: out_degenerate,
                nx: out_new_x, ny: out_new_y};
        if (resolve_q.size() == 0) begin
          if (fail_count < 10) $display("ERROR: unexpected result %p", got);
          fail_count <= fail_count + 1;
        end else begin
          e = resolve_q.pop_front();
          if (got !== e) begin
            if (fail_count < 10) $display("ERROR: mismatch expected %p actual %p", e, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* sim/circle_box_collision_resolve_tb.sv */
// Testbench top for the collision resolver: clock, reset, stimulus and verdict.
module circle_box_collision_resolve_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 400000;

  logic               clk, rst_n, start, busy;
  logic signed [31:0] in_circle_x, in_circle_y, in_box_x, in_box_y;
  logic [30:0]        in_circle_radius, in_box_width, in_box_height;
  logic               in_trigger, cfg_valid, cfg_ready;
  logic [15:0]        cfg_data;
  logic               out_valid, out_hit, out_moved, out_degenerate;
  logic signed [31:0] out_new_x, out_new_y;
  int                 fail_count, pending;
  longint             cycles;
  logic               quiet;

  circle_box_collision_resolve dut (.*);
  cbcr_checker chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Bound the run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL circle_box_collision_resolve");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 40) << 16;
      3: return -($urandom_range(0, 40) << 16);
      default: return $urandom();
    endcase
  endfunction

  // Hold one request until accepted, with random idle cycles first
  task automatic send(logic [31:0] cx, logic [31:0] cy, logic [30:0] rad, logic [31:0] bx,
                      logic [31:0] by, logic [30:0] bw, logic [30:0] bh, logic trig);
    while (!quiet && $urandom_range(0, 99) < 26) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_circle_x <= cx;
    in_circle_y <= cy;
    in_circle_radius <= rad;
    in_box_x <= bx;
    in_box_y <= by;
    in_box_width <= bw;
    in_box_height <= bh;
    in_trigger <= trig;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Near-contact pair around a small box: mostly hits with random content
  task automatic send_near();
    logic [31:0] bx, by;
    logic [30:0] bw, bh, rad;
    bx = rnd_word() >>> 2;
    by = rnd_word() >>> 2;
    bw = 31'($urandom_range(0, 8) << 16 | $urandom_range(0, 65535));
    bh = 31'($urandom_range(0, 8) << 16 | $urandom_range(0, 65535));
    rad = 31'($urandom_range(0, 6) << 16 | $urandom_range(0, 65535));
    send(bx + $signed($urandom_range(0, 20 << 16)) - (10 << 16),
         by + $signed($urandom_range(0, 20 << 16)) - (10 << 16),
         rad, bx, by, bw, bh, $urandom_range(0, 3) == 0);
  endtask

  // Write the tolerance register while idle
  task automatic write_tol(logic [15:0] v);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (cbcr_pkg::PIPE_LAT + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] tols[5];
    tols = '{16'd0, 16'd65535, 16'd1, 16'd300, 16'd7};
    rst_n = 0; start = 0; cfg_valid = 0; cfg_data = 0; quiet = 0;
    in_circle_x = 0; in_circle_y = 0; in_circle_radius = 0; in_box_x = 0;
    in_box_y = 0; in_box_width = 0; in_box_height = 0; in_trigger = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: inside, edge contact, tolerance band, trigger, far apart, extremes
    send(0, 0, 31'(1 << 16), 0, 0, 31'(4 << 16), 31'(4 << 16), 0);
    send(0, 0, 0, 0, 0, 0, 0, 0);
    send(3 << 16, 0, 31'(1 << 16), 0, 0, 31'(4 << 16), 31'(4 << 16), 0);
    send(3 << 16, 0, 31'(1 << 16), 0, 0, 31'(4 << 16), 31'(4 << 16), 1);
    send((3 << 16) + 1, 0, 31'(1 << 16), 0, 0, 31'(4 << 16), 31'(4 << 16), 0);
    send((3 << 16) + 2, 0, 31'(1 << 16), 0, 0, 31'(4 << 16), 31'(4 << 16), 0);
    send(5 << 16, 5 << 16, 31'(1 << 16), 0, 0, 31'(2 << 16), 31'(2 << 16), 0);
    send(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         0, 0, 0);
    send(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
         31'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
         0, 0, 1);
    send(32'h7FFF_0000, 0, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 2, 2, 0);
    send(32'h8000_0000, 0, 31'h7FFF_FFFF, 32'h8000_0000 + 10, 0, 4, 0, 0);
    send(0, 0, 31'h7FFF_FFFF, 32'h6000_0000, 32'h6000_0000, 0, 0, 0);
    send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 0, 0, 31'h7FFF_FFFF, 1, 1);

    // Random phases across tolerance settings
    for (int ph = 0; ph < 5; ph++) begin
      write_tol(tols[ph]);
      for (int i = 0; i < 210; i++) begin
        quiet = (ph == 2 && i >= 60 && i < 150);
        if ($urandom_range(0, 99) < 80) send_near();
        else send(rnd_word(), rnd_word(), 31'(rnd_word()), rnd_word(), rnd_word(),
                  31'(rnd_word()), 31'(rnd_word()), $urandom_range(0, 1));
      end
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (cbcr_pkg::PIPE_LAT + 10) @(posedge clk);
    if (fail_count == 0) $display("PASS circle_box_collision_resolve");
    else $display("FAIL circle_box_collision_resolve");
    $finish;
  end
endmodule

/* files.f */
sv/cbcr_pkg.sv
sv/cbcr_sqrt.sv
sv/cbcr_div.sv
sv/circle_box_collision_resolve.sv
sv/cbcr_checker.sv
sim/cbcr_checker.sv
sim/circle_box_collision_resolve_tb.sv
